@@ sv/fsd_pkg.sv @@
// Shared constants, codes and types of the per-source flood detector.
`default_nettype none
package fsd_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int USED_W      = $clog2(TABLE_DEPTH + 1);

  localparam int ADDR_W  = 48;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 16;
  localparam int WIN_W   = 16;
  localparam int SLOT_W  = 8;
  localparam int STAT_W  = 2;
  localparam int ENTRY_W = TIME_W + COUNT_W;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = COUNT_W'(50);
  localparam logic [WIN_W-1:0]   WINDOW_RESET    = WIN_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COUNT_THRESHOLD = 1'b0,
    REG_WINDOW_SECONDS  = 1'b1
  } cfg_reg_t;

  typedef enum logic [STAT_W-1:0] {
    STATUS_NONE   = 2'd0,
    STATUS_ATTACK = 2'd1,
    STATUS_FULL   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_t;

  // Result of the per-entry update rule.
  typedef struct packed {
    status_t             status;
    logic                write;
    logic [COUNT_W-1:0]  count;
    logic [TIME_W-1:0]   start;
  } upd_t;

endpackage
`default_nettype wire

@@ sv/fsd_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM with registered read.
`default_nettype none
module fsd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ sv/fsd_update.sv @@
// Count and window rule applied to one table entry after a lookup.
`default_nettype none
module fsd_update (
  input  wire logic                          hit,
  input  wire logic                          full,
  input  wire logic [fsd_pkg::COUNT_W-1:0]   stored_count,
  input  wire logic [fsd_pkg::TIME_W-1:0]    stored_start,
  input  wire logic [fsd_pkg::TIME_W-1:0]    now_seconds,
  input  wire logic [fsd_pkg::COUNT_W-1:0]   count_threshold,
  input  wire logic [fsd_pkg::WIN_W-1:0]     window_seconds,
  output fsd_pkg::upd_t                      upd
);

  logic [fsd_pkg::COUNT_W-1:0] count_inc;
  logic [fsd_pkg::TIME_W-1:0]  start_cur;
  logic [fsd_pkg::TIME_W-1:0]  elapsed;
  logic                        in_window;

  always_comb begin
    if (hit) begin
      count_inc = (stored_count == '1) ? stored_count
                                       : stored_count + fsd_pkg::COUNT_W'(1);
      start_cur = stored_start;
    end else begin
      count_inc = fsd_pkg::COUNT_W'(1);
      start_cur = now_seconds;
    end
    // Elapsed time wraps modulo 2^32 like the time source itself.
    elapsed   = now_seconds - start_cur;
    in_window = elapsed <= fsd_pkg::TIME_W'(window_seconds);

    upd.status = fsd_pkg::STATUS_NONE;
    upd.write  = 1'b1;
    upd.count  = count_inc;
    upd.start  = start_cur;
    if (full) begin
      upd.status = fsd_pkg::STATUS_FULL;
      upd.write  = 1'b0;
      upd.count  = '0;
    end else if (count_inc >= count_threshold && in_window) begin
      upd.status = fsd_pkg::STATUS_ATTACK;
      upd.count  = '0;
      upd.start  = now_seconds;
    end else if (!in_window) begin
      upd.count  = fsd_pkg::COUNT_W'(1);
      upd.start  = now_seconds;
    end
  end

endmodule
`default_nettype wire

@@ sv/per_source_flood_detector.sv @@
// Top level of the per-source flood detector: lookup sequencer and table memories.
//
// Each request on the s_axis channel carries a 48-bit source address and the
// current time in seconds. The block scans its address table from slot 0 up,
// one slot per cycle through a read pipeline on the address memory, then reads,
// updates and writes back the matching entry (count and window start time), or
// appends a new entry on a miss if the table has room. One result per request
// leaves on m_axis: status, slot index and the entry's count after this frame.
// The scan of the address memory sets how long a request takes: a hit in slot k
// ends the scan at that slot, a miss scans every used entry.
// Requests are handled one at a time; a new request is taken once the previous
// one has reached the output register, even while that result still waits.
// If the receiver stalls, the result holds and the block waits in its final
// step until the output register frees up.
// Reset (rst, synchronous) empties the table, clears the output and loads the
// threshold of 50 frames and the window of 1 second. The cfg port writes these
// registers; the user must use it only while no request is in flight. The block
// itself does not enforce this.
`default_nettype none
module per_source_flood_detector (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [47:0] source_address, [79:48] now_seconds
  input  wire logic [fsd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [1:0] status, [9:2] entry_index, [25:10] entry_count, [31:26] zero
  output logic      [fsd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [fsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fsd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  fsd_pkg::state_t state, state_next;

  logic [fsd_pkg::COUNT_W-1:0] count_threshold;
  logic [fsd_pkg::WIN_W-1:0]   window_seconds;
  logic [fsd_pkg::USED_W-1:0]  entries_used;

  logic [fsd_pkg::ADDR_W-1:0]  src_addr;
  logic [fsd_pkg::TIME_W-1:0]  now_sec;

  logic [fsd_pkg::USED_W-1:0]  issue_idx;
  logic                        cmp_pending;
  logic [fsd_pkg::IDX_W-1:0]   cmp_idx;
  logic                        hit;
  logic [fsd_pkg::IDX_W-1:0]   hit_idx;

  logic                        s_accept;
  logic                        issue_rd;
  logic                        match;
  logic                        scan_done;
  logic                        out_free;
  logic                        finish;
  logic                        full;
  logic [fsd_pkg::IDX_W-1:0]   slot;

  logic [fsd_pkg::ADDR_W-1:0]  addr_rdata;
  logic [fsd_pkg::ENTRY_W-1:0] entry_rdata;
  logic                        addr_we;
  logic                        entry_we;
  logic                        entry_re;

  fsd_pkg::upd_t upd;

  assign s_accept  = s_axis_tvalid && s_axis_tready;
  assign issue_rd  = (state == fsd_pkg::ST_SEARCH) && (issue_idx < entries_used);
  assign match     = (state == fsd_pkg::ST_SEARCH) && cmp_pending && (addr_rdata == src_addr);
  assign scan_done = (state == fsd_pkg::ST_SEARCH) && !cmp_pending && !issue_rd;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign finish    = (state == fsd_pkg::ST_UPDATE) && out_free;
  assign full      = !hit && (entries_used == fsd_pkg::USED_W'(fsd_pkg::TABLE_DEPTH));
  assign slot      = hit ? hit_idx : entries_used[fsd_pkg::IDX_W-1:0];
  assign addr_we   = finish && !hit && !full;
  assign entry_we  = finish && upd.write;
  // The entry read follows each compare, so a match finds its entry ready next cycle.
  assign entry_re  = (state == fsd_pkg::ST_SEARCH) && cmp_pending;

  fsd_ram #(
    .WIDTH(fsd_pkg::ADDR_W),
    .DEPTH(fsd_pkg::TABLE_DEPTH)
  ) u_addr_ram (
    .clk  (clk),
    .we   (addr_we),
    .waddr(slot),
    .wdata(src_addr),
    .re   (issue_rd),
    .raddr(issue_idx[fsd_pkg::IDX_W-1:0]),
    .rdata(addr_rdata)
  );

  fsd_ram #(
    .WIDTH(fsd_pkg::ENTRY_W),
    .DEPTH(fsd_pkg::TABLE_DEPTH)
  ) u_entry_ram (
    .clk  (clk),
    .we   (entry_we),
    .waddr(slot),
    .wdata({upd.start, upd.count}),
    .re   (entry_re),
    .raddr(cmp_idx),
    .rdata(entry_rdata)
  );

  fsd_update u_update (
    .hit            (hit),
    .full           (full),
    .stored_count   (entry_rdata[fsd_pkg::COUNT_W-1:0]),
    .stored_start   (entry_rdata[fsd_pkg::ENTRY_W-1:fsd_pkg::COUNT_W]),
    .now_seconds    (now_sec),
    .count_threshold(count_threshold),
    .window_seconds (window_seconds),
    .upd            (upd)
  );

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    case (state)
      fsd_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = fsd_pkg::ST_SEARCH;
        end
      end
      fsd_pkg::ST_SEARCH: begin
        if (match || scan_done) begin
          state_next = fsd_pkg::ST_UPDATE;
        end
      end
      fsd_pkg::ST_UPDATE: begin
        if (out_free) begin
          state_next = fsd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fsd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fsd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_threshold <= fsd_pkg::THRESHOLD_RESET;
      window_seconds  <= fsd_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      case (fsd_pkg::cfg_reg_t'(cfg_index))
        fsd_pkg::REG_COUNT_THRESHOLD: count_threshold <= cfg_data;
        fsd_pkg::REG_WINDOW_SECONDS:  window_seconds  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Scan control.
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_used  <= '0;
      issue_idx     <= '0;
      cmp_pending   <= 1'b0;
      hit           <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_accept) begin
        issue_idx   <= '0;
        cmp_pending <= 1'b0;
        hit         <= 1'b0;
      end else if (state == fsd_pkg::ST_SEARCH) begin
        cmp_pending <= issue_rd;
        if (issue_rd) begin
          issue_idx <= issue_idx + fsd_pkg::USED_W'(1);
        end
        if (match) begin
          hit <= 1'b1;
        end
      end
      if (addr_we) begin
        entries_used <= entries_used + fsd_pkg::USED_W'(1);
      end
      if (finish) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      src_addr <= s_axis_tdata[fsd_pkg::ADDR_W-1:0];
      now_sec  <= s_axis_tdata[fsd_pkg::ADDR_W +: fsd_pkg::TIME_W];
    end
    if (issue_rd) begin
      cmp_idx <= issue_idx[fsd_pkg::IDX_W-1:0];
    end
    if (match) begin
      hit_idx <= cmp_idx;
    end
    if (finish) begin
      m_axis_tdata <= {(fsd_pkg::OUT_DATA_W - fsd_pkg::STAT_W - fsd_pkg::SLOT_W
                        - fsd_pkg::COUNT_W)'(0),
                       upd.count,
                       full ? fsd_pkg::SLOT_W'(0) : fsd_pkg::SLOT_W'(slot),
                       upd.status};
    end
  end

endmodule
`default_nettype wire

@@ dv/per_source_flood_detector_tb.sv @@
// Self-checking testbench for the per-source flood detector.
module per_source_flood_detector_tb;

  localparam int HOLD_CYCLES = 1500;
  localparam int SETTLE_CYCLES = fsd_pkg::TABLE_DEPTH + 20;

  typedef struct {
    fsd_pkg::status_t            status;
    logic [fsd_pkg::SLOT_W-1:0]  slot;
    logic [fsd_pkg::COUNT_W-1:0] count;
  } flood_verdict_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [fsd_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [fsd_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           cfg_we = 1'b0;
  fsd_pkg::cfg_reg_t              cfg_index = fsd_pkg::REG_COUNT_THRESHOLD;
  logic [fsd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the detector table and its settings.
  logic [fsd_pkg::ADDR_W-1:0]  seen_addr [fsd_pkg::TABLE_DEPTH];
  logic [fsd_pkg::TIME_W-1:0]  window_start [fsd_pkg::TABLE_DEPTH];
  logic [fsd_pkg::COUNT_W-1:0] seen_count [fsd_pkg::TABLE_DEPTH];
  int unsigned                 slots_used = 0;
  logic [fsd_pkg::COUNT_W-1:0] attack_threshold = fsd_pkg::THRESHOLD_RESET;
  logic [fsd_pkg::WIN_W-1:0]   window_len = fsd_pkg::WINDOW_RESET;

  flood_verdict_t verdicts_pending[$];
  logic [fsd_pkg::TIME_W-1:0] wall_seconds = '0;

  int mismatches = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int attacks_predicted = 0;
  int drops_predicted = 0;

  logic steady_flow = 1'b0;
  logic hold_start = 1'b0;
  int   hold_left = 0;

  per_source_flood_detector u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #6000000;
    $display("tb: failure");
    $finish;
  end

  // Applies one frame to the shadow table and returns the expected result.
  function automatic flood_verdict_t predict_verdict(
      input logic [fsd_pkg::ADDR_W-1:0] addr, input logic [fsd_pkg::TIME_W-1:0] now);
    flood_verdict_t v;
    int unsigned slot;
    bit hit;
    logic [fsd_pkg::TIME_W-1:0] elapsed;
    v.status = fsd_pkg::STATUS_NONE;
    slot = 0;
    hit = 1'b0;
    for (int unsigned i = 0; i < slots_used; i++) begin
      if (!hit && seen_addr[i] == addr) begin
        slot = i;
        hit = 1'b1;
      end
    end
    if (hit) begin
      if (seen_count[slot] != '1)
        seen_count[slot] = seen_count[slot] + fsd_pkg::COUNT_W'(1);
    end else if (slots_used >= fsd_pkg::TABLE_DEPTH) begin
      v.status = fsd_pkg::STATUS_FULL;
      v.slot = '0;
      v.count = '0;
      return v;
    end else begin
      slot = slots_used;
      seen_addr[slot] = addr;
      seen_count[slot] = fsd_pkg::COUNT_W'(1);
      window_start[slot] = now;
      slots_used++;
    end
    elapsed = now - window_start[slot];
    if (seen_count[slot] >= attack_threshold &&
        elapsed <= fsd_pkg::TIME_W'(window_len)) begin
      seen_count[slot] = '0;
      window_start[slot] = now;
      v.status = fsd_pkg::STATUS_ATTACK;
    end else if (elapsed > fsd_pkg::TIME_W'(window_len)) begin
      seen_count[slot] = fsd_pkg::COUNT_W'(1);
      window_start[slot] = now;
    end
    v.slot = slot[fsd_pkg::SLOT_W-1:0];
    v.count = seen_count[slot];
    return v;
  endfunction

  function automatic logic [fsd_pkg::ADDR_W-1:0] fresh_address();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[fsd_pkg::ADDR_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [fsd_pkg::ADDR_W-1:0] got,
                                 input logic [fsd_pkg::ADDR_W-1:0] want);
    mismatches++;
    $display("tb: mismatch in %s: got %0h, expected %0h", what, got, want);
  endtask

  // Result checker: every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin
    flood_verdict_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (verdicts_pending.size() == 0) begin
        report_mismatch("unexpected result", fsd_pkg::ADDR_W'(m_axis_tdata), '0);
      end else begin
        want = verdicts_pending.pop_front();
        results_checked++;
        if (m_axis_tdata[1:0] != want.status)
          report_mismatch("status", fsd_pkg::ADDR_W'(m_axis_tdata[1:0]),
                          fsd_pkg::ADDR_W'(want.status));
        if (m_axis_tdata[9:2] != want.slot)
          report_mismatch("entry_index", fsd_pkg::ADDR_W'(m_axis_tdata[9:2]),
                          fsd_pkg::ADDR_W'(want.slot));
        if (m_axis_tdata[25:10] != want.count)
          report_mismatch("entry_count", fsd_pkg::ADDR_W'(m_axis_tdata[25:10]),
                          fsd_pkg::ADDR_W'(want.count));
        if (m_axis_tdata[31:26] != '0)
          report_mismatch("padding", fsd_pkg::ADDR_W'(m_axis_tdata[31:26]), '0);
      end
    end
  end

  // Receiver: random stalls, a stretch without stalls, and one long hold-off on request.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_start) begin
      m_axis_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else begin
      m_axis_tready <= steady_flow || ($urandom_range(99) >= 7);
    end
  end

  task automatic send_frame(input logic [fsd_pkg::ADDR_W-1:0] addr,
                            input logic [fsd_pkg::TIME_W-1:0] now);
    flood_verdict_t v;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {now, addr};
    do @(posedge clk); while (!s_axis_tready);
    v = predict_verdict(addr, now);
    verdicts_pending.push_back(v);
    requests_sent++;
    if (v.status == fsd_pkg::STATUS_ATTACK) attacks_predicted++;
    if (v.status == fsd_pkg::STATUS_FULL) drops_predicted++;
    if (!steady_flow && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Stops offering requests and waits until every expected result has arrived.
  task automatic drain_requests();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (verdicts_pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input fsd_pkg::cfg_reg_t which,
                                input logic [fsd_pkg::CFG_DATA_W-1:0] value);
    drain_requests();
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (which)
      fsd_pkg::REG_COUNT_THRESHOLD: attack_threshold = value;
      fsd_pkg::REG_WINDOW_SECONDS:  window_len = value;
      default: ;
    endcase
  endtask

  task automatic program_limits(input logic [fsd_pkg::COUNT_W-1:0] threshold,
                                input logic [fsd_pkg::WIN_W-1:0] window);
    write_register(fsd_pkg::REG_COUNT_THRESHOLD, threshold);
    write_register(fsd_pkg::REG_WINDOW_SECONDS, window);
  endtask

  // Mostly repeat traffic from a few busy sources, some from any tracked source,
  // and a share of new sources, half of them one bit away from a tracked one.
  task automatic random_frames(input int count, input int fresh_pct);
    int unsigned hot_first;
    int roll;
    int step;
    logic [fsd_pkg::ADDR_W-1:0] addr;
    hot_first = (slots_used == 0) ? 0 : $urandom_range(slots_used - 1);
    repeat (count) begin
      step = $urandom_range(99);
      if (step < 2) wall_seconds = $urandom;
      else if (step < 10) wall_seconds += $urandom_range(2, 70000);
      else if (step < 40) wall_seconds += 1;
      roll = $urandom_range(99);
      if (slots_used == 0 || roll < fresh_pct) begin
        if (slots_used != 0 && roll[0])
          addr = seen_addr[$urandom_range(slots_used - 1)] ^ (48'd1 << $urandom_range(47));
        else
          addr = fresh_address();
      end else if (roll < fresh_pct + 55) begin
        addr = seen_addr[(hot_first + $urandom_range(3)) % slots_used];
      end else begin
        addr = seen_addr[$urandom_range(slots_used - 1)];
      end
      send_frame(addr, wall_seconds);
    end
  endtask

  task automatic test_reset_defaults();
    send_frame('0, '0);
    send_frame('1, '1);
    send_frame('0, 32'd1);
    // Elapsed time beyond the window restarts the count.
    send_frame('0, 32'd3);
    // Time wrapped from all ones to zero: one second elapsed.
    send_frame('1, '0);
  endtask

  task automatic test_special_cases();
    // A threshold of one flags a new source at once.
    program_limits(16'd1, 16'd0);
    send_frame(48'h8000_0000_0000, 32'h8000_0000);
    send_frame(48'h8000_0000_0000, 32'h8000_0000);
    // A threshold of zero flags every frame within the window.
    program_limits(16'd0, 16'hFFFF);
    send_frame('0, 32'd1000);
    send_frame(48'h5555_5555_5555, 32'hAAAA_AAAA);
    // Zero window: only frames in the same second count together.
    program_limits(16'd3, 16'd0);
    repeat (3) send_frame(48'hAAAA_AAAA_AAAA, 32'h5555_5555);
    send_frame(48'hAAAA_AAAA_AAAA, 32'h5555_5556);
    // Largest threshold and window, elapsed exactly at and far beyond the window.
    program_limits(16'hFFFF, 16'hFFFF);
    send_frame(48'hAAAA_AAAA_AAAA, 32'h5555_5556 + 32'd65535);
    send_frame(48'hAAAA_AAAA_AAAA, 32'h5555_5556 + 32'd131071);
    // Window that spans the wrap of the seconds counter.
    program_limits(16'd2, 16'd10);
    send_frame(48'h1234_5678_9ABC, 32'hFFFF_FFFC);
    send_frame(48'h1234_5678_9ABC, 32'h0000_0003);
    send_frame(48'h1234_5678_9ABD, 32'h0000_0003);
  endtask

  task automatic test_random_traffic();
    program_limits(16'd2, 16'd0);
    random_frames(150, 8);
    program_limits(16'd4, 16'd3);
    steady_flow <= 1'b1;
    random_frames(150, 8);
    steady_flow <= 1'b0;
    program_limits(16'd1, 16'hFFFF);
    random_frames(150, 8);
    program_limits(16'd6, 16'd1);
    random_frames(150, 8);
    program_limits(16'hFFFF, 16'hFFFF);
    random_frames(150, 8);
    program_limits(16'd0, 16'($urandom_range(0, 20)));
    random_frames(150, 8);
    program_limits(16'($urandom_range(1, 12)), 16'($urandom_range(0, 20)));
    random_frames(150, 8);
  endtask

  task automatic test_table_full();
    program_limits(16'd4, 16'd10);
    while (slots_used < fsd_pkg::TABLE_DEPTH) begin
      wall_seconds += 1;
      send_frame(fresh_address(), wall_seconds);
    end
    // New sources are dropped now, while tracked ones, the last slot too, still count.
    repeat (60) begin
      case ($urandom_range(2))
        0: send_frame(fresh_address(), wall_seconds);
        1: send_frame(seen_addr[fsd_pkg::TABLE_DEPTH - 1], wall_seconds);
        default: send_frame(seen_addr[$urandom_range(fsd_pkg::TABLE_DEPTH - 1)],
                            wall_seconds);
      endcase
    end
  endtask

  task automatic test_backpressure();
    program_limits(16'd3, 16'd5);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    // The sender keeps offering while the stalled output holds the results back.
    repeat (10) send_frame(seen_addr[$urandom_range(3)], wall_seconds);
    program_limits(16'd3, 16'd2);
    random_frames(150, 20);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_special_cases();
    test_random_traffic();
    test_table_full();
    test_backpressure();
    drain_requests();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("tb: %0d requests sent, %0d results checked, %0d mismatches",
             requests_sent, results_checked, mismatches);
    $display("tb: %0d attacks and %0d full-table drops expected, %0d slots in use",
             attacks_predicted, drops_predicted, slots_used);
    if (mismatches == 0 && verdicts_pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
